[rtl/sine_taylor_quadrant_unit_assert.svh]
// Assertion macros for the sine Taylor quadrant unit.
`ifndef SINE_TAYLOR_QUADRANT_UNIT_ASSERT_SVH
`define SINE_TAYLOR_QUADRANT_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, quiet during reset.
`define STQ_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stq assertion failed");

// Next-cycle implication, quiet during reset.
`define STQ_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stq assertion failed");

`else

`define STQ_ASSERT_IMP(label, clk, rst, ante, cons)
`define STQ_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

[rtl/stq_pkg.sv]
// Shared widths, constants and types of the sine Taylor quadrant unit.
package stq_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int WORK_BITS     = 24;
  localparam int IN_W          = FRACTION_BITS + 3;
  localparam int OUT_W         = FRACTION_BITS + 2;
  localparam int WIDEN_SH      = WORK_BITS - FRACTION_BITS;
  localparam int IN_TDATA_W    = ((IN_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W   = ((OUT_W + 7) / 8) * 8;

  // angle at 24 fraction bits, reduced angle, its square, Horner term
  localparam int A_W  = IN_W + WIDEN_SH;
  localparam int X_W  = 25;
  localparam int X2_W = 26;
  localparam int T_W  = 26;

  localparam int N_CELLS = 4;

  localparam logic [A_W-1:0] K_HALF_PI       = A_W'(26353589);
  localparam logic [A_W-1:0] K_PI            = A_W'(52707178);
  localparam logic [A_W-1:0] K_THREE_HALF_PI = A_W'(79060767);
  localparam logic [A_W-1:0] K_TWO_PI        = A_W'(105414357);

  typedef logic signed [T_W-1:0] coef_t;

  localparam coef_t R_F9 = T_W'(46);
  localparam coef_t R_F8 = T_W'(416);

  // Horner coefficients, first cell first
  localparam coef_t SIN_COEF [N_CELLS] = '{T_W'(3328), T_W'(139810), T_W'(2796202),
                                           T_W'(16777216)};
  localparam coef_t COS_COEF [N_CELLS] = '{T_W'(23301), T_W'(699050), T_W'(8388608),
                                           T_W'(16777216)};

  localparam logic signed [T_W:0]     SAT_LIM = (T_W+1)'(1 << FRACTION_BITS);
  localparam logic signed [OUT_W-1:0] OUT_LIM = OUT_W'(1 << FRACTION_BITS);

  typedef struct packed {
    logic valid;
    logic use_cos;  // cosine series (quadrants 2 and 4)
    logic neg;      // negate result (quadrants 3 and 4)
    logic oor;      // angle above two pi
  } stq_ctl_t;

endpackage

[rtl/stq_reduce.sv]
// Quadrant decode and base subtraction stage.
module stq_reduce (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [stq_pkg::IN_W-1:0]   angle,
  output stq_pkg::stq_ctl_t          ctl,
  output logic [stq_pkg::X_W-1:0]    x
);

  logic [stq_pkg::A_W-1:0] a;
  logic [stq_pkg::A_W-1:0] base;
  logic [stq_pkg::A_W-1:0] diff;
  stq_pkg::stq_ctl_t       ctl_next;

  always_comb begin
    a    = stq_pkg::A_W'(angle) << stq_pkg::WIDEN_SH;
    ctl_next       = '0;
    ctl_next.valid = in_valid;
    base           = '0;
    if (a < stq_pkg::K_HALF_PI) begin
      base = '0;
    end else if (a < stq_pkg::K_PI) begin
      base = stq_pkg::K_HALF_PI;
      ctl_next.use_cos = 1'b1;
    end else if (a < stq_pkg::K_THREE_HALF_PI) begin
      base = stq_pkg::K_PI;
      ctl_next.neg = 1'b1;
    end else if (a <= stq_pkg::K_TWO_PI) begin
      base = stq_pkg::K_THREE_HALF_PI;
      ctl_next.use_cos = 1'b1;
      ctl_next.neg     = 1'b1;
    end else begin
      base = a;  // x reads as zero, result forced later
      ctl_next.oor = 1'b1;
    end
    diff = a - base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl <= ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x <= diff[stq_pkg::X_W-1:0];
    end
  end

endmodule

[rtl/stq_square.sv]
// Squares the reduced angle and seeds the Horner term.
module stq_square (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  stq_pkg::stq_ctl_t           ctl_in,
  input  logic [stq_pkg::X_W-1:0]     x_in,
  output stq_pkg::stq_ctl_t           ctl,
  output logic [stq_pkg::X_W-1:0]     x,
  output logic [stq_pkg::X2_W-1:0]    x2,
  output stq_pkg::coef_t              t
);

  logic [2*stq_pkg::X_W-1:0] prod;

  assign prod = x_in * x_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x  <= x_in;
      x2 <= prod[stq_pkg::X2_W+stq_pkg::WORK_BITS-1:stq_pkg::WORK_BITS];
      t  <= ctl_in.use_cos ? stq_pkg::R_F8 : stq_pkg::R_F9;
    end
  end

endmodule

[rtl/stq_horner_cell.sv]
// One Horner step: t <= c - floor(x2 * t / 2^24).
module stq_horner_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  stq_pkg::coef_t              coef_sin,
  input  stq_pkg::coef_t              coef_cos,
  input  stq_pkg::stq_ctl_t           ctl_in,
  input  logic [stq_pkg::X_W-1:0]     x_in,
  input  logic [stq_pkg::X2_W-1:0]    x2_in,
  input  stq_pkg::coef_t              t_in,
  output stq_pkg::stq_ctl_t           ctl,
  output logic [stq_pkg::X_W-1:0]     x,
  output logic [stq_pkg::X2_W-1:0]    x2,
  output stq_pkg::coef_t              t
);

  localparam int M_W = stq_pkg::T_W + 1;

  logic signed [M_W-1:0]     x2_s;
  logic signed [M_W-1:0]     t_s;
  logic signed [2*M_W-1:0]   prod;
  logic signed [2*M_W-1:0]   prod_sh;
  logic signed [M_W:0]       t_wide;
  stq_pkg::coef_t            coef;

  always_comb begin
    x2_s    = signed'({1'b0, x2_in});
    t_s     = M_W'(t_in);
    prod    = x2_s * t_s;
    prod_sh = prod >>> stq_pkg::WORK_BITS;  // floor
    coef    = ctl_in.use_cos ? coef_cos : coef_sin;
    t_wide  = (M_W+1)'(coef) - prod_sh[M_W:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x  <= x_in;
      x2 <= x2_in;
      t  <= t_wide[stq_pkg::T_W-1:0];
    end
  end

endmodule

[rtl/stq_post.sv]
// Final sine multiply by x; cosine passes the Horner term through.
module stq_post (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  stq_pkg::stq_ctl_t        ctl_in,
  input  logic [stq_pkg::X_W-1:0]  x_in,
  input  stq_pkg::coef_t           t_in,
  output stq_pkg::stq_ctl_t        ctl,
  output stq_pkg::coef_t           r
);

  logic signed [stq_pkg::T_W-1:0]   x_s;
  logic signed [2*stq_pkg::T_W-1:0] prod;
  logic signed [2*stq_pkg::T_W-1:0] prod_sh;

  always_comb begin
    x_s     = signed'({1'b0, x_in});
    prod    = x_s * t_in;
    prod_sh = prod >>> stq_pkg::WORK_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r <= ctl_in.use_cos ? t_in : prod_sh[stq_pkg::T_W-1:0];
    end
  end

endmodule

[rtl/sine_taylor_quadrant_unit.sv]
// Top level of the sine Taylor quadrant unit: pipeline of Horner cells and output skid.
//
// Usage:
//  - Input stream s_*: one angle per word, unsigned Q3.16 radians in s_tdata[18:0].
//  - Output stream m_*: sine in m_tdata[17:0] (signed Q1.16, clipped to +/-1),
//    out-of-range flag in m_tuser (angle above two pi, sine forced to zero).
//  - Path: a word accepted on s_* passes the registers of decode, square, four
//    Horner cells, final multiply and output register before it reaches m_tvalid.
//  - Throughput: one word per cycle sustained while m_tready stays high; each
//    pipeline stage holds at most one multiplier, the four Horner cells set the depth.
//  - Every word in gives exactly one word out, in order.
//  - Stall: when m_tready is low the output register holds, one more word
//    lands in the skid register, and s_tready drops (it is a flop output)
//    until the skid drains; the whole pipeline freezes meanwhile.
//  - Reset (rst, synchronous, active high) empties the pipeline, output and
//    skid registers; s_tready is high in the first cycle after reset.
`include "sine_taylor_quadrant_unit_assert.svh"

module sine_taylor_quadrant_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [stq_pkg::IN_TDATA_W-1:0]     s_tdata,   // [18:0] angle
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [stq_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [17:0] sine_value
  output logic                               m_tuser    // [0] out_of_range
);

  localparam int NC = stq_pkg::N_CELLS;

  // Pipeline advances only while the skid register is empty.
  logic en;

  stq_pkg::stq_ctl_t              red_ctl;
  logic [stq_pkg::X_W-1:0]        red_x;

  stq_pkg::stq_ctl_t              cell_ctl [NC+1];
  logic [stq_pkg::X_W-1:0]        cell_x   [NC+1];
  logic [stq_pkg::X2_W-1:0]       cell_x2  [NC+1];
  stq_pkg::coef_t                 cell_t   [NC+1];

  stq_pkg::stq_ctl_t              post_ctl;
  stq_pkg::coef_t                 post_r;

  // Output formatting
  logic signed [stq_pkg::T_W-1:0] r_sh;
  logic signed [stq_pkg::T_W:0]   r_ext;
  logic signed [stq_pkg::T_W:0]   r_sgn;
  logic signed [stq_pkg::T_W:0]   r_sat;
  logic [stq_pkg::OUT_W-1:0]      res_sine;

  // Output register and skid
  logic                           o_valid;
  logic [stq_pkg::OUT_W-1:0]      o_sine;
  logic                           o_oor;
  logic                           skid_valid;
  logic [stq_pkg::OUT_W-1:0]      skid_sine;
  logic                           skid_oor;

  assign en       = !skid_valid;
  assign s_tready = en;

  stq_reduce u_reduce (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .angle    (s_tdata[stq_pkg::IN_W-1:0]),
    .ctl      (red_ctl),
    .x        (red_x)
  );

  stq_square u_square (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .ctl_in (red_ctl),
    .x_in   (red_x),
    .ctl    (cell_ctl[0]),
    .x      (cell_x[0]),
    .x2     (cell_x2[0]),
    .t      (cell_t[0])
  );

  for (genvar i = 0; i < NC; i++) begin : g_cell
    stq_horner_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .coef_sin (stq_pkg::SIN_COEF[i]),
      .coef_cos (stq_pkg::COS_COEF[i]),
      .ctl_in   (cell_ctl[i]),
      .x_in     (cell_x[i]),
      .x2_in    (cell_x2[i]),
      .t_in     (cell_t[i]),
      .ctl      (cell_ctl[i+1]),
      .x        (cell_x[i+1]),
      .x2       (cell_x2[i+1]),
      .t        (cell_t[i+1])
    );
  end

  stq_post u_post (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .ctl_in (cell_ctl[NC]),
    .x_in   (cell_x[NC]),
    .t_in   (cell_t[NC]),
    .ctl    (post_ctl),
    .r      (post_r)
  );

  // Floor to output precision, apply quadrant sign, clip to +/-1, force zero when out of range.
  always_comb begin
    r_sh  = post_r >>> stq_pkg::WIDEN_SH;
    r_ext = (stq_pkg::T_W+1)'(r_sh);
    r_sgn = post_ctl.neg ? -r_ext : r_ext;
    if (r_sgn > stq_pkg::SAT_LIM) begin
      r_sat = stq_pkg::SAT_LIM;
    end else if (r_sgn < -stq_pkg::SAT_LIM) begin
      r_sat = -stq_pkg::SAT_LIM;
    end else begin
      r_sat = r_sgn;
    end
    res_sine = post_ctl.oor ? '0 : r_sat[stq_pkg::OUT_W-1:0];
  end

  // Output register with one-deep skid.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid    <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !o_valid) begin
      if (skid_valid) begin
        o_valid    <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        o_valid <= post_ctl.valid;
      end
    end else if (post_ctl.valid && en) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !o_valid) begin
      if (skid_valid) begin
        o_sine <= skid_sine;
        o_oor  <= skid_oor;
      end else begin
        o_sine <= res_sine;
        o_oor  <= post_ctl.oor;
      end
    end else if (post_ctl.valid && en) begin
      skid_sine <= res_sine;
      skid_oor  <= post_ctl.oor;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = stq_pkg::OUT_TDATA_W'(o_sine);
  assign m_tuser  = o_oor;

  // Checks
  logic signed [stq_pkg::OUT_W-1:0] sine_chk;
  logic                             sine_in_lim;

  assign sine_chk    = signed'(o_sine);
  assign sine_in_lim = (sine_chk <= stq_pkg::OUT_LIM) && (sine_chk >= -stq_pkg::OUT_LIM);

  `STQ_ASSERT_IMP(a_skid_needs_out, clk, rst, skid_valid, o_valid)
  `STQ_ASSERT_NXT(a_skid_holds, clk, rst, skid_valid && !m_tready, skid_valid)
  `STQ_ASSERT_IMP(a_oor_zero, clk, rst, o_valid && o_oor, o_sine == '0)
  `STQ_ASSERT_IMP(a_sine_clip, clk, rst, o_valid, sine_in_lim)

endmodule
